// ===== src/hich_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the heading block.
// No dependencies; imported by hard_iron_calibrated_heading.
package hich_pkg;

    // Operation codes carried with each input word
    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_FINISH = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ITER,
        ST_MUL,
        ST_DONE
    } t_state;

    // CORDIC configuration
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int STEP_W           = 5;
    localparam int PRESCALE_SH      = 12;

    // Angle widths: full turn is 2^32, accumulator carries sign and headroom
    localparam int Z_W = 34;
    localparam logic signed [Z_W-1:0] QUARTER_TURN = 34'sd1073741824;

    // Turn-to-unit scale factors
    localparam logic [31:0] RAD_Q13_SCALE = 32'd3373259426;
    localparam logic [31:0] DEG_Q7_SCALE  = 32'd46080;

    // Arctangent of 2^-i in binary angle units (full turn 2^32)
    function automatic logic [31:0] atan_turns(input logic [STEP_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/hard_iron_calibrated_heading.sv =====
// Hard-iron calibration and compass heading: a query is loaded and pre-rotated, makes
// STEPS passes through the one shared shift-add CORDIC stage, where STEPS is CORDIC_STEPS
// capped at 24, goes through the 32x32 turn-to-unit multiplier and is handed to the
// output register; a query on the zero vector skips the CORDIC passes, and start, sample
// and finish words go straight to the hand-off. The input is stalled while a word is in
// work, and a finished word waits in work while the output register is full and stalled.
// The output register holds a finished word while the next input word is accepted.
// Depends on hich_pkg.
module hard_iron_calibrated_heading #(
    parameter int CORDIC_STEPS = hich_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic               i_cfg_data,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_operation,
    input  logic signed [15:0] i_sample_x,
    input  logic signed [15:0] i_sample_y,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_bearing,
    output logic               o_bearing_valid,
    output logic signed [15:0] o_offset_x,
    output logic signed [15:0] o_offset_y
);
    import hich_pkg::*;

    localparam int STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

    t_state r_state, n_state;

    logic               r_angle_unit;
    logic signed [15:0] r_max_x, r_min_x, r_max_y, r_min_y;
    logic signed [15:0] r_center_x, r_center_y;

    logic signed [31:0]      r_x, r_y;
    logic signed [Z_W-1:0]   r_z;
    logic [STEP_W-1:0]       r_step;
    logic                    r_is_query;
    logic [63:0]             r_prod;

    logic w_accept, w_load_out, w_zero;

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_accept   = 1'b0;
        w_load_out = 1'b0;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    w_accept = 1'b1;
                    if (i_operation == OP_QUERY && !w_zero) begin
                        n_state = ST_ITER;
                    end else if (i_operation == OP_QUERY) begin
                        n_state = ST_MUL;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_ITER: begin
                if (r_step == LAST_STEP) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!o_out_valid || !i_out_stall) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_unit <= 1'b0;
        end else if (i_cfg_we) begin
            r_angle_unit <= i_cfg_data;
        end
    end

    // ---------------------------------------------------------------
    // Calibration: min/max tracking and center (truncated toward zero)
    // ---------------------------------------------------------------
    logic signed [16:0] w_sum_x, w_sum_y, w_adj_x, w_adj_y;

    assign w_sum_x = {r_max_x[15], r_max_x} + {r_min_x[15], r_min_x};
    assign w_sum_y = {r_max_y[15], r_max_y} + {r_min_y[15], r_min_y};
    assign w_adj_x = w_sum_x + {16'd0, w_sum_x[16]};
    assign w_adj_y = w_sum_y + {16'd0, w_sum_y[16]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_x    <= '0;
            r_min_x    <= '0;
            r_max_y    <= '0;
            r_min_y    <= '0;
            r_center_x <= '0;
            r_center_y <= '0;
        end else if (w_accept) begin
            case (i_operation)
                OP_START: begin
                    r_max_x <= i_sample_x;
                    r_min_x <= i_sample_x;
                    r_max_y <= i_sample_y;
                    r_min_y <= i_sample_y;
                end
                OP_SAMPLE: begin
                    if (i_sample_x > r_max_x) begin
                        r_max_x <= i_sample_x;
                    end else if (i_sample_x < r_min_x) begin
                        r_min_x <= i_sample_x;
                    end
                    if (i_sample_y > r_max_y) begin
                        r_max_y <= i_sample_y;
                    end else if (i_sample_y < r_min_y) begin
                        r_min_y <= i_sample_y;
                    end
                end
                OP_FINISH: begin
                    r_center_x <= w_adj_x[16:1];
                    r_center_y <= w_adj_y[16:1];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Query front end: remove offset, prescale, pre-rotate into right half
    // ---------------------------------------------------------------
    logic signed [16:0] w_dx, w_dy;
    logic signed [31:0] w_x0, w_y0, w_xp, w_yp;
    logic signed [Z_W-1:0] w_zp;

    assign w_dx   = {i_sample_x[15], i_sample_x} - {r_center_x[15], r_center_x};
    assign w_dy   = {i_sample_y[15], i_sample_y} - {r_center_y[15], r_center_y};
    assign w_zero = (w_dx == '0) && (w_dy == '0);
    // CORDIC x axis takes dy, y axis takes dx
    assign w_x0   = {{3{w_dy[16]}}, w_dy, {PRESCALE_SH{1'b0}}};
    assign w_y0   = {{3{w_dx[16]}}, w_dx, {PRESCALE_SH{1'b0}}};

    always_comb begin
        w_xp = w_x0;
        w_yp = w_y0;
        w_zp = '0;
        if (w_x0 < 0) begin
            if (w_y0 >= 0) begin
                w_xp = w_y0;
                w_yp = -w_x0;
                w_zp = QUARTER_TURN;
            end else begin
                w_xp = -w_y0;
                w_yp = w_x0;
                w_zp = -QUARTER_TURN;
            end
        end
    end

    // ---------------------------------------------------------------
    // Shared CORDIC stage, one micro-rotation per cycle
    // ---------------------------------------------------------------
    logic signed [31:0]    w_xs, w_ys;
    logic signed [Z_W-1:0] w_atan;

    assign w_xs   = r_x >>> r_step;
    assign w_ys   = r_y >>> r_step;
    assign w_atan = Z_W'(atan_turns(r_step));

    // ---------------------------------------------------------------
    // Turn-to-unit multiplier
    // ---------------------------------------------------------------
    logic [31:0] w_turns, w_scale;
    logic [63:0] w_prod;

    assign w_turns = 32'd0 - r_z[31:0];
    assign w_scale = r_angle_unit ? DEG_Q7_SCALE : RAD_Q13_SCALE;
    assign w_prod  = 64'(w_turns) * 64'(w_scale);

    // Datapath registers for the query
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_is_query <= (i_operation == OP_QUERY);
            r_step     <= '0;
            if (w_zero) begin
                r_x <= '0;
                r_y <= '0;
                r_z <= '0;
            end else begin
                r_x <= w_xp;
                r_y <= w_yp;
                r_z <= w_zp;
            end
        end else if (r_state == ST_ITER) begin
            r_step <= r_step + 1'b1;
            if (r_y >= 0) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_atan;
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_atan;
            end
        end
        if (r_state == ST_MUL) begin
            r_prod <= w_prod;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_load_out) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            o_bearing_valid <= r_is_query;
            o_offset_x      <= r_center_x;
            o_offset_y      <= r_center_y;
            if (!r_is_query) begin
                o_bearing <= '0;
            end else if (r_angle_unit) begin
                o_bearing <= r_prod[47:32];
            end else begin
                o_bearing <= r_prod[63:48];
            end
        end
    end

endmodule
